// ----- hdl/prit_pkg.sv -----
// shared types and constants for the packed record index table
`default_nettype none

package prit_pkg;

  localparam int DEF_MAX_ENTRIES       = 255;
  localparam int DEF_FIRST_DATA_OFFSET = 2117;

  localparam int OFFSET_W = 32;
  localparam int SIZE_W   = 24;
  localparam int EXTENT_W = 16;
  localparam int DEPTH_W  = 8;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 8;

  localparam int IN_BITS  = 2 + INDEX_W + SIZE_W + 2 * EXTENT_W + DEPTH_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 1 + OFFSET_W + COUNT_W + OFFSET_W + 2 * EXTENT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_BITS;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

endpackage

`default_nettype wire

// ----- hdl/packed_record_index_table_unit.sv -----
// packed record index table: offset/size tables with add, insert, remove and query
//
//   channel | dir | fields (low bit first)
//   s_*     | in  | action 2, entry_index 8, record_size 24, record_width 16,
//           |     | record_height 16, record_depth 8, zero pad 6
//   m_*     | out | ok 1, entry_offset 32, entry_count 8, cursor_now 32,
//           |     | widest 16, tallest 16, zero pad 7
//
// add and rejected actions go straight to the result, query reads one entry, insert
// moves the entries from the index up one slot, and remove adjusts every entry's offset
// and closes the gap, one entry at a time over the single read port and write port.
// s_tready is high only between items; one finished result may wait in the
// output register while the next item is taken, and a second one holds the last cycle.
// rst is synchronous; the entry memory is not cleared.
`default_nettype none

module packed_record_index_table_unit
  import prit_pkg::*;
#(
  parameter int          MAX_ENTRIES       = DEF_MAX_ENTRIES,
  parameter logic [31:0] FIRST_DATA_OFFSET = DEF_FIRST_DATA_OFFSET
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // action, entry_index, record_size, record_width, record_height, record_depth
  input  wire logic [IN_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // ok, entry_offset, entry_count, cursor_now, widest, tallest
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_RM_HEAD,
    S_RM_PASS,
    S_QRY,
    S_DONE
  } state_t;

  state_t state;

  // input fields
  action_t             in_action;
  logic [INDEX_W-1:0]  in_idx;
  logic [SIZE_W-1:0]   in_size;
  logic [EXTENT_W-1:0] in_w;
  logic [EXTENT_W-1:0] in_h;
  logic [DEPTH_W-1:0]  in_depth;

  assign in_action = action_t'(s_tdata[1:0]);
  assign in_idx    = s_tdata[9:2];
  assign in_size   = s_tdata[33:10];
  assign in_w      = s_tdata[49:34];
  assign in_h      = s_tdata[65:50];
  assign in_depth  = s_tdata[73:66];

  // architectural state
  logic [CNT_W-1:0]    count;
  logic [OFFSET_W-1:0] cursor;
  logic [DEPTH_W-1:0]  bank_depth;
  logic [EXTENT_W-1:0] widest;
  logic [EXTENT_W-1:0] tallest;

  // per-item working registers
  logic [CNT_W-1:0]    idx_r;
  logic [SIZE_W-1:0]   sz_r;
  logic [EXTENT_W-1:0] w_r;
  logic [EXTENT_W-1:0] h_r;
  logic [CNT_W-1:0]    ptr;
  logic                pend;
  logic [AW-1:0]       pend_i;
  logic [OFFSET_W-1:0] roff;
  logic [SIZE_W-1:0]   rsize;
  logic                res_ok;
  logic [OFFSET_W-1:0] res_off;

  // entry memory
  entry_t        mem [MAX_ENTRIES];
  entry_t        rd_data;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // decisions
  logic                accept;
  logic [CMP_W-1:0]    idx_ext;
  logic [CMP_W-1:0]    cnt_ext;
  logic                full;
  logic                first;
  logic [OFFSET_W-1:0] add_base;
  logic                add_ok;
  logic                ins_ok;
  logic                in_range;
  logic [CNT_W-1:0]    ptr_m1;
  logic [CNT_W-1:0]    pend_ext;
  logic [OFFSET_W-1:0] adj_off;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx_ext  = CMP_W'(in_idx);
  assign cnt_ext  = CMP_W'(count);
  assign full     = (count == CNT_W'(MAX_ENTRIES));
  assign first    = (cursor == '0) || (count == '0);
  assign add_base = first ? FIRST_DATA_OFFSET : cursor;
  assign add_ok   = !full && (first || (in_depth == bank_depth));
  assign ins_ok   = !full && (idx_ext <= cnt_ext);
  assign in_range = (idx_ext < cnt_ext);
  assign ptr_m1   = ptr - CNT_W'(1);
  assign pend_ext = CNT_W'(pend_i);
  assign adj_off  = (rd_data.offset > roff) ? (rd_data.offset - OFFSET_W'(rsize))
                                            : rd_data.offset;

  always_comb begin
    mem_raddr = idx_ext[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (in_action == ACT_ADD) && add_ok) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_ext[AW-1:0];
          mem_wdata = '{size: in_size, offset: add_base};
        end
      end
      S_INS: begin
        mem_raddr = ptr_m1[AW-1:0];
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_i;
          mem_wdata = rd_data;
        end else if (ptr == idx_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r[AW-1:0];
          mem_wdata = '{size: sz_r, offset: cursor};
        end
      end
      S_RM_PASS: begin
        mem_raddr = ptr[AW-1:0];
        if (pend && (pend_ext != idx_r)) begin
          mem_we    = 1'b1;
          mem_waddr = (pend_ext > idx_r) ? (pend_i - AW'(1)) : pend_i;
          mem_wdata = '{size: rd_data.size, offset: adj_off};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      cursor     <= '0;
      bank_depth <= '0;
      widest     <= '0;
      tallest    <= '0;
      pend       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx_r   <= idx_ext[CNT_W-1:0];
            sz_r    <= in_size;
            w_r     <= in_w;
            h_r     <= in_h;
            ptr     <= count;
            pend    <= 1'b0;
            res_ok  <= 1'b0;
            res_off <= '0;
            state   <= S_DONE;
            unique case (in_action)
              ACT_ADD: begin
                if (add_ok) begin
                  if (first) begin
                    bank_depth <= in_depth;
                  end
                  cursor  <= add_base + OFFSET_W'(in_size);
                  count   <= count + CNT_W'(1);
                  if (in_w > widest) begin
                    widest <= in_w;
                  end
                  if (in_h > tallest) begin
                    tallest <= in_h;
                  end
                  res_ok  <= 1'b1;
                  res_off <= add_base;
                end
              end
              ACT_INSERT: begin
                if (ins_ok) begin
                  state <= S_INS;
                end
              end
              ACT_REMOVE: begin
                if (in_range) begin
                  state <= S_RM_HEAD;
                end
              end
              ACT_QUERY: begin
                if (in_range) begin
                  state <= S_QRY;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_QRY: begin
          res_ok  <= 1'b1;
          res_off <= rd_data.offset;
          state   <= S_DONE;
        end
        S_INS: begin
          if (ptr > idx_r) begin
            pend   <= 1'b1;
            pend_i <= ptr[AW-1:0];
            ptr    <= ptr_m1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              cursor  <= cursor + OFFSET_W'(sz_r);
              count   <= count + CNT_W'(1);
              if (w_r > widest) begin
                widest <= w_r;
              end
              if (h_r > tallest) begin
                tallest <= h_r;
              end
              res_ok  <= 1'b1;
              res_off <= cursor;
              state   <= S_DONE;
            end
          end
        end
        S_RM_HEAD: begin
          roff  <= rd_data.offset;
          rsize <= rd_data.size;
          ptr   <= '0;
          pend  <= 1'b0;
          state <= S_RM_PASS;
        end
        S_RM_PASS: begin
          if (ptr < count) begin
            pend   <= 1'b1;
            pend_i <= ptr[AW-1:0];
            ptr    <= ptr + CNT_W'(1);
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count   <= count - CNT_W'(1);
              cursor  <= cursor - OFFSET_W'(rsize);
              res_ok  <= 1'b1;
              res_off <= roff;
              state   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{OUT_PAD{1'b0}}, tallest, widest, cursor,
                         cnt_ext[COUNT_W-1:0], res_off, res_ok};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- dv/record_index_check_pkg.sv -----
// request/result types and scoreboard for the packed record index table bench
package record_index_check_pkg;
  import prit_pkg::*;

  typedef struct {
    action_t             act;
    bit [INDEX_W-1:0]    slot;
    bit [SIZE_W-1:0]     rec_size;
    bit [EXTENT_W-1:0]   rec_width;
    bit [EXTENT_W-1:0]   rec_height;
    bit [DEPTH_W-1:0]    rec_depth;
  } index_request_t;

  typedef struct {
    bit                  ok;
    bit [OFFSET_W-1:0]   offset;
    bit [COUNT_W-1:0]    count;
    bit [OFFSET_W-1:0]   cursor;
    bit [EXTENT_W-1:0]   widest;
    bit [EXTENT_W-1:0]   tallest;
  } index_result_t;

  class index_table_scoreboard;
    bit [OFFSET_W-1:0] offset_tbl [DEF_MAX_ENTRIES];
    bit [SIZE_W-1:0]   size_tbl [DEF_MAX_ENTRIES];
    int                entries;
    bit [OFFSET_W-1:0] cursor;
    bit [DEPTH_W-1:0]  bank_depth;
    bit [EXTENT_W-1:0] widest;
    bit [EXTENT_W-1:0] tallest;
    index_result_t     awaited[$];
    int                errors;
    int                checked;
    int                rejected;
    int                peak;
    int                per_action [4];

    function new();
      entries = 0;
      cursor = '0;
      bank_depth = '0;
      widest = '0;
      tallest = '0;
      errors = 0;
      checked = 0;
      rejected = 0;
      peak = 0;
      foreach (per_action[a]) per_action[a] = 0;
    endfunction

    function void grow_extent(index_request_t req);
      if (req.rec_width > widest) widest = req.rec_width;
      if (req.rec_height > tallest) tallest = req.rec_height;
    endfunction

    // apply one accepted transfer to the shadow table and queue its result
    function void note_request(index_request_t req);
      index_result_t     res;
      bit [SIZE_W-1:0]   gone;
      int                i;
      res.ok = 1'b0;
      res.offset = '0;
      case (req.act)
        ACT_ADD: begin
          if (entries < DEF_MAX_ENTRIES) begin
            if (cursor == 0 || entries == 0) begin
              cursor = OFFSET_W'(DEF_FIRST_DATA_OFFSET);
              bank_depth = req.rec_depth;
            end
            if (req.rec_depth == bank_depth) begin
              res.offset = cursor;
              offset_tbl[entries] = cursor;
              size_tbl[entries] = req.rec_size;
              cursor = cursor + OFFSET_W'(req.rec_size);
              grow_extent(req);
              entries++;
              res.ok = 1'b1;
            end
          end
        end
        ACT_INSERT: begin
          if (entries < DEF_MAX_ENTRIES && req.slot <= entries) begin
            for (i = entries; i > req.slot; i--) begin
              offset_tbl[i] = offset_tbl[i-1];
              size_tbl[i] = size_tbl[i-1];
            end
            res.offset = cursor;
            offset_tbl[req.slot] = cursor;
            size_tbl[req.slot] = req.rec_size;
            cursor = cursor + OFFSET_W'(req.rec_size);
            entries++;
            grow_extent(req);
            res.ok = 1'b1;
          end
        end
        ACT_REMOVE: begin
          if (req.slot < entries) begin
            gone = size_tbl[req.slot];
            res.offset = offset_tbl[req.slot];
            for (i = 0; i < entries; i++) begin
              if (offset_tbl[i] > res.offset) offset_tbl[i] = offset_tbl[i] - OFFSET_W'(gone);
            end
            for (i = req.slot; i + 1 < entries; i++) begin
              offset_tbl[i] = offset_tbl[i+1];
              size_tbl[i] = size_tbl[i+1];
            end
            entries--;
            offset_tbl[entries] = '0;
            size_tbl[entries] = '0;
            cursor = cursor - OFFSET_W'(gone);
            res.ok = 1'b1;
          end
        end
        default: begin
          if (req.slot < entries) begin
            res.offset = offset_tbl[req.slot];
            res.ok = 1'b1;
          end
        end
      endcase
      res.count = COUNT_W'(entries);
      res.cursor = cursor;
      res.widest = widest;
      res.tallest = tallest;
      per_action[req.act]++;
      if (!res.ok) rejected++;
      if (entries > peak) peak = entries;
      awaited.push_back(res);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(index_result_t got);
      index_result_t want;
      if (awaited.size() == 0) begin
        $error("result transfer with nothing pending: ok %0d offset 0x%0h",
               got.ok, got.offset);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("ok", want.ok, got.ok);
      compare_field("entry_offset", want.offset, got.offset);
      compare_field("entry_count", want.count, got.count);
      compare_field("cursor_now", want.cursor, got.cursor);
      compare_field("widest", want.widest, got.widest);
      compare_field("tallest", want.tallest, got.tallest);
    endfunction
  endclass

endpackage

// ----- dv/testbench.sv -----
// top-level bench: drives the record index table with directed and random transfers
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prit_pkg::*;
  import record_index_check_pkg::*;

  typedef enum {MIX_GROW, MIX_CHURN, MIX_SHRINK} traffic_mix_t;

  localparam int DRAIN_CYCLES = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  index_table_scoreboard book = new();
  int                    results_seen = 0;
  bit                    long_hold_done = 1'b0;

  traffic_mix_t phase_mix [6] = '{MIX_GROW, MIX_CHURN, MIX_SHRINK, MIX_GROW, MIX_SHRINK,
                                  MIX_CHURN};
  int           phase_items [6] = '{450, 200, 500, 300, 250, 200};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  packed_record_index_table_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic logic [IN_W-1:0] pack_request(index_request_t r);
    logic [IN_W-1:0] v;
    v = '0;
    v[IN_BITS-1:0] = {r.rec_depth, r.rec_height, r.rec_width, r.rec_size, r.slot, r.act};
    return v;
  endfunction

  function automatic index_request_t mk(action_t a, bit [7:0] slot, bit [23:0] rec_size,
                                        bit [15:0] w, bit [15:0] h, bit [7:0] dep);
    index_request_t r;
    r.act = a;
    r.slot = slot;
    r.rec_size = rec_size;
    r.rec_width = w;
    r.rec_height = h;
    r.rec_depth = dep;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic index_request_t make_request(traffic_mix_t mix);
    index_request_t r;
    int             pick;
    int             live;
    int             t_add;
    int             t_ins;
    int             t_rem;
    live = book.entries;
    case (mix)
      MIX_GROW:   begin t_add = 60; t_ins = 85; t_rem = 90; end
      MIX_SHRINK: begin t_add = 8;  t_ins = 14; t_rem = 80; end
      default:    begin t_add = 25; t_ins = 50; t_rem = 75; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < t_add) r.act = ACT_ADD;
    else if (pick < t_ins) r.act = ACT_INSERT;
    else if (pick < t_rem) r.act = ACT_REMOVE;
    else r.act = ACT_QUERY;

    if ($urandom_range(0, 9) == 0 || r.act == ACT_ADD) r.slot = 8'($urandom_range(0, 255));
    else if (r.act == ACT_INSERT) r.slot = 8'($urandom_range(0, live));
    else r.slot = (live > 0) ? 8'($urandom_range(0, live - 1)) : 8'd0;

    pick = $urandom_range(0, 99);
    if (pick < 65) r.rec_size = 24'($urandom_range(0, 4095));
    else if (pick < 90) r.rec_size = 24'($urandom());
    else if (pick < 95) r.rec_size = '0;
    else r.rec_size = '1;

    r.rec_width = ($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 65535))
                                             : 16'($urandom_range(0, 1023));
    r.rec_height = ($urandom_range(0, 9) < 3) ? 16'($urandom_range(0, 65535))
                                              : 16'($urandom_range(0, 1023));

    if (live == 0 || $urandom_range(0, 9) == 0) r.rec_depth = 8'($urandom_range(0, 255));
    else r.rec_depth = book.bank_depth;
    return r;
  endfunction

  task automatic send_request(index_request_t req, bit eager);
    int gap;
    s_tdata <= pack_request(req);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    book.note_request(req);
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (book.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(mk(ACT_QUERY, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_REMOVE, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_INSERT, 8'd1, 24'd5, 16'd1, 16'd1, 8'd0), 1'b0);
    // insert on an empty table keeps a zero cursor and does not latch depth
    send_request(mk(ACT_INSERT, 8'd0, 24'd0, 16'hFFFF, 16'd0, 8'hFF), 1'b0);
    // first add with a zero cursor restarts at the data base and latches depth
    send_request(mk(ACT_ADD, 8'd0, 24'h10, 16'd3, 16'd4, 8'hA5), 1'b0);
    send_request(mk(ACT_ADD, 8'd0, 24'h20, 16'd3, 16'd4, 8'h5A), 1'b0);
    send_request(mk(ACT_ADD, 8'hFF, 24'hFFFFFF, 16'd0, 16'hFFFF, 8'hA5), 1'b1);
    send_request(mk(ACT_INSERT, 8'hFF, 24'd9, 16'd0, 16'd0, 8'hA5), 1'b0);
    send_request(mk(ACT_INSERT, 8'd3, 24'h123, 16'd7, 16'd7, 8'h00), 1'b1);
    send_request(mk(ACT_INSERT, 8'd0, 24'd7, 16'd8, 16'd8, 8'h33), 1'b0);
    send_request(mk(ACT_QUERY, 8'hFF, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_QUERY, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b1);
    send_request(mk(ACT_QUERY, 8'd4, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_REMOVE, 8'd1, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_REMOVE, 8'd4, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_REMOVE, 8'd3, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_ADD, 8'd0, 24'd0, 16'h8000, 16'd2, 8'hA5), 1'b0);
    repeat (4) send_request(mk(ACT_REMOVE, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    send_request(mk(ACT_REMOVE, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
    // empty table with a nonzero cursor: add restarts and latches a new depth
    send_request(mk(ACT_ADD, 8'd0, 24'd100, 16'd1, 16'd1, 8'h00), 1'b0);
    send_request(mk(ACT_QUERY, 8'd0, 24'd0, 16'd0, 16'd0, 8'd0), 1'b0);
  endtask

  always @(posedge clk) begin
    index_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.ok = m_tdata[0];
      got.offset = m_tdata[32:1];
      got.count = m_tdata[40:33];
      got.cursor = m_tdata[72:41];
      got.widest = m_tdata[88:73];
      got.tallest = m_tdata[104:89];
      book.check_result(got);
      results_seen++;
    end
  end

  // result side: short and long stalls, steady stretches, one long hold-off
  initial begin
    int stall_left;
    int steady_left;
    stall_left = 0;
    steady_left = 0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= 700) begin
        long_hold_done = 1'b1;
        stall_left = 600;
      end else if (stall_left == 0 && steady_left == 0) begin
        if ($urandom_range(0, 299) == 0) steady_left = 200;
        else if ($urandom_range(0, 7) == 0)
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) :
                                                      $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (steady_left > 0) steady_left--;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_for_drain();
    foreach (phase_mix[p]) begin
      for (int n = 0; n < phase_items[p]; n++) send_request(make_request(phase_mix[p]), n < 40);
      wait_for_drain();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d transfers: %0d add, %0d insert, %0d remove, %0d query, %0d rejected",
             book.checked, book.per_action[ACT_ADD], book.per_action[ACT_INSERT],
             book.per_action[ACT_REMOVE], book.per_action[ACT_QUERY], book.rejected);
    $display("table fill peaked at %0d of %0d entries, ended at %0d",
             book.peak, DEF_MAX_ENTRIES, book.entries);
    if (book.errors == 0 && book.awaited.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
